>>> rtl/core/bsc_pkg.sv
// bsc_pkg: shared constants, stream field positions and the command/status
// structs that join the bifid square controller and its datapath.
// No dependencies.
package bsc_pkg;

    // Parameter defaults
    localparam int DEF_SQUARE_SIDE      = 6;
    localparam int DEF_MESSAGE_CAPACITY = 64;

    // Stream field layout
    localparam int SYM_W       = 8;     // symbol byte
    localparam int CIDX_W      = 6;     // cell_index field
    localparam int SYM_LO      = CIDX_W;
    localparam int S_TDATA_W   = 16;    // cell_index + symbol, padded to bytes
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;
    localparam int USER_UNK    = 0;     // m_tuser bit: unknown symbol seen
    localparam int USER_OVF    = 1;     // m_tuser bit: capacity overflow
    localparam int REV_DEPTH   = 256;   // one reverse-map entry per byte value

    // Input action codes (s_tuser)
    localparam logic ACT_CELL = 1'b0;
    localparam logic ACT_MSG  = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;      // capture input word
        logic look;        // read square at item cell, reverse map at item symbol
        logic store;       // append looked-up coordinate to message
        logic tupd;        // write square cell, update map of new symbol
        logic rd_old;      // read reverse map at displaced symbol
        logic scan_start;  // clear scan counters and candidate
        logic scan_step;   // read next square cell for the rescan
        logic fix;         // write rescan result for displaced symbol
        logic ord;         // read the two message coordinates of result k
        logic osq;         // read square at fractionated (row, col)
        logic out_load;    // load output register, advance k
    } bsc_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic item_msg;    // captured word is a message symbol
        logic item_last;   // captured word carries tlast
        logic item_rng;    // captured cell index is inside the square
        logic need_old;    // overwritten cell held another symbol
        logic old_hit;     // displaced symbol was mapped to this cell
        logic scan_end;    // scan is issuing its final cell
        logic out_free;    // output register can take a word
        logic k_final;     // current result is the last of the message
    } bsc_stat_t;

endpackage

>>> rtl/core/bsc_ctrl.sv
// bsc_ctrl: one-hot sequencer for table writes, message loads and the
// fractionation/output phase. Depends on bsc_pkg (command/status structs).
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bsc_stat_t stat,
    output bsc_cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_LOOK   = 12'b0000_0000_0010,
        ST_STORE  = 12'b0000_0000_0100,
        ST_TUPD   = 12'b0000_0000_1000,
        ST_ROLD   = 12'b0000_0001_0000,
        ST_CHK    = 12'b0000_0010_0000,
        ST_SCAN   = 12'b0000_0100_0000,
        ST_SDRAIN = 12'b0000_1000_0000,
        ST_FIX    = 12'b0001_0000_0000,
        ST_ORD    = 12'b0010_0000_0000,
        ST_OSQ    = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.look = 1'b1;
                if (stat.item_msg) begin
                    state_next = ST_STORE;
                end else if (stat.item_rng) begin
                    state_next = ST_TUPD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = stat.item_last ? ST_ORD : ST_IDLE;
            end
            ST_TUPD: begin
                cmd.tupd   = 1'b1;
                state_next = stat.need_old ? ST_ROLD : ST_IDLE;
            end
            ST_ROLD: begin
                cmd.rd_old = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // only a rescan if the displaced symbol pointed at this cell
                if (stat.old_hit) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end) begin
                    state_next = ST_SDRAIN;
                end
            end
            ST_SDRAIN: begin
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ORD: begin
                cmd.ord    = 1'b1;
                state_next = ST_OSQ;
            end
            ST_OSQ: begin
                cmd.osq    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.k_final ? ST_IDLE : ST_ORD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/bsc_dp.sv
// bsc_dp: datapath with square, reverse-map and message memories, rescan
// logic, coordinate fractionation and the output register.
// Depends on bsc_pkg; driven by bsc_ctrl commands.
module bsc_dp
    import bsc_pkg::*;
#(
    parameter int SQUARE_SIDE      = DEF_SQUARE_SIDE,
    parameter int MESSAGE_CAPACITY = DEF_MESSAGE_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  bsc_cmd_t             cmd,
    output bsc_stat_t            stat
);

    localparam int RC_W       = $clog2(SQUARE_SIDE);
    localparam int COORD_W    = 2 * RC_W;
    localparam int CELL_COUNT = SQUARE_SIDE * SQUARE_SIDE;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int ADDR_W     = $clog2(MESSAGE_CAPACITY);
    localparam int CNT_W      = $clog2(MESSAGE_CAPACITY + 1);
    localparam int POS_W      = $clog2(2 * MESSAGE_CAPACITY);

    // coordinate {row, col} -> linear square address
    function automatic logic [CELL_W-1:0] cell_addr(input logic [COORD_W-1:0] c);
        return CELL_W'(int'(c[COORD_W-1:RC_W]) * SQUARE_SIDE + int'(c[RC_W-1:0]));
    endfunction

    // ---------------- input decode ----------------
    logic [CIDX_W-1:0] in_cell;
    logic [SYM_W-1:0]  in_sym;
    logic [RC_W-1:0]   in_row, in_col;

    assign in_cell = s_tdata[CIDX_W-1:0];
    assign in_sym  = s_tdata[SYM_LO +: SYM_W];

    // split cell index into row/col by constant compares
    always_comb begin
        in_row = '0;
        in_col = RC_W'(in_cell);
        for (int r = 1; r < SQUARE_SIDE; r++) begin
            if (int'(in_cell) >= r * SQUARE_SIDE) begin
                in_row = RC_W'(r);
                in_col = RC_W'(int'(in_cell) - r * SQUARE_SIDE);
            end
        end
    end

    logic [SYM_W-1:0]   sym_reg;
    logic [COORD_W-1:0] item_coord_reg;
    logic               item_msg_reg, item_last_reg, item_rng_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sym_reg        <= in_sym;
            item_coord_reg <= {in_row, in_col};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_msg_reg  <= 1'b0;
            item_last_reg <= 1'b0;
            item_rng_reg  <= 1'b0;
        end else if (cmd.accept) begin
            item_msg_reg  <= (s_tuser == ACT_MSG);
            item_last_reg <= s_tlast;
            item_rng_reg  <= (int'(in_cell) < CELL_COUNT);
        end
    end

    // ---------------- direction register ----------------
    logic dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= 1'b0;
        end else if (cfg_valid) begin
            dir_reg <= cfg_data;
        end
    end

    // ---------------- scan counters ----------------
    logic [RC_W-1:0]    scan_row_reg, scan_col_reg;
    logic               cmp_vld_reg, cmp_loaded_reg;
    logic [COORD_W-1:0] cmp_coord_reg;
    logic [COORD_W-1:0] cand_reg;
    logic               cand_found_reg;
    logic               scan_at_end;

    assign scan_at_end = (scan_row_reg == RC_W'(SQUARE_SIDE - 1))
                      && (scan_col_reg == RC_W'(SQUARE_SIDE - 1));

    // ---------------- message coordinate reads ----------------
    logic [CNT_W-1:0]   count_reg, k_reg;
    logic               unk_reg, ovf_reg;
    logic [COORD_W-1:0] ca_reg, cb_reg;
    logic               a_col_reg, b_col_reg;
    logic [RC_W-1:0]    out_row, out_col;
    logic               k_final;

    assign out_row = a_col_reg ? ca_reg[RC_W-1:0] : ca_reg[COORD_W-1:RC_W];
    assign out_col = b_col_reg ? cb_reg[RC_W-1:0] : cb_reg[COORD_W-1:RC_W];
    assign k_final = (CNT_W'(k_reg + 1'b1) == count_reg);

    // ---------------- square memory ----------------
    logic [SYM_W-1:0]      sq_mem [CELL_COUNT];
    logic [SYM_W-1:0]      sq_rd_reg;
    logic [CELL_W-1:0]     sq_rd_addr;
    logic                  sq_rd_en;
    logic [CELL_COUNT-1:0] cell_loaded_reg;

    always_comb begin
        if (cmd.scan_step) begin
            sq_rd_addr = cell_addr({scan_row_reg, scan_col_reg});
        end else if (cmd.osq) begin
            sq_rd_addr = cell_addr({out_row, out_col});
        end else begin
            sq_rd_addr = cell_addr(item_coord_reg);
        end
    end

    assign sq_rd_en = cmd.look | cmd.scan_step | cmd.osq;

    always_ff @(posedge aclk) begin
        if (cmd.tupd) begin
            sq_mem[cell_addr(item_coord_reg)] <= sym_reg;
        end
        if (sq_rd_en) begin
            sq_rd_reg <= sq_mem[sq_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_loaded_reg <= '0;
        end else if (cmd.tupd) begin
            cell_loaded_reg[cell_addr(item_coord_reg)] <= 1'b1;
        end
    end

    // ---------------- reverse map ----------------
    logic [COORD_W-1:0]   rev_mem [REV_DEPTH];
    logic [REV_DEPTH-1:0] rev_valid_reg;
    logic [COORD_W-1:0]   rev_rd_reg;
    logic                 rev_vld_rd_reg;
    logic [SYM_W-1:0]     old_reg;
    logic [SYM_W-1:0]     rev_rd_addr, rev_wa;
    logic [COORD_W-1:0]   rev_wd;
    logic                 rev_rd_en, rev_we, sym_wins;

    // new symbol takes this cell if unmapped or mapped to a lower cell
    assign sym_wins    = !rev_vld_rd_reg || (item_coord_reg > rev_rd_reg);
    assign rev_rd_addr = cmd.rd_old ? old_reg : sym_reg;
    assign rev_rd_en   = cmd.look | cmd.rd_old;
    assign rev_we      = (cmd.tupd && sym_wins) || cmd.fix;
    assign rev_wa      = cmd.fix ? old_reg : sym_reg;
    assign rev_wd      = cmd.fix ? cand_reg : item_coord_reg;

    always_ff @(posedge aclk) begin
        if (rev_we) begin
            rev_mem[rev_wa] <= rev_wd;
        end
        if (rev_rd_en) begin
            rev_rd_reg <= rev_mem[rev_rd_addr];
        end
        if (cmd.tupd) begin
            old_reg <= sq_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rev_valid_reg  <= '0;
            rev_vld_rd_reg <= 1'b0;
        end else begin
            if (rev_we) begin
                rev_valid_reg[rev_wa] <= cmd.fix ? cand_found_reg : 1'b1;
            end
            if (rev_rd_en) begin
                rev_vld_rd_reg <= rev_valid_reg[rev_rd_addr];
            end
        end
    end

    // ---------------- rescan for displaced symbol ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cand_found_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= cmd.scan_step;
            if (cmd.scan_start) begin
                scan_row_reg   <= '0;
                scan_col_reg   <= '0;
                cand_found_reg <= 1'b0;
            end else begin
                if (cmd.scan_step) begin
                    if (scan_col_reg == RC_W'(SQUARE_SIDE - 1)) begin
                        scan_col_reg <= '0;
                        scan_row_reg <= scan_row_reg + 1'b1;
                    end else begin
                        scan_col_reg <= scan_col_reg + 1'b1;
                    end
                end
                // ascending scan: last match is the highest cell
                if (cmp_vld_reg && cmp_loaded_reg && (sq_rd_reg == old_reg)) begin
                    cand_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            cmp_coord_reg  <= {scan_row_reg, scan_col_reg};
            cmp_loaded_reg <= cell_loaded_reg[cell_addr({scan_row_reg, scan_col_reg})];
        end
        if (cmp_vld_reg && cmp_loaded_reg && (sq_rd_reg == old_reg)) begin
            cand_reg <= cmp_coord_reg;
        end
    end

    // ---------------- message store ----------------
    logic [COORD_W-1:0] msg_mem [MESSAGE_CAPACITY];
    logic               msg_full;

    assign msg_full = (count_reg >= CNT_W'(MESSAGE_CAPACITY));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            unk_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
        end else begin
            if (cmd.store) begin
                if (!msg_full) begin
                    count_reg <= count_reg + 1'b1;
                    if (!rev_vld_rd_reg) begin
                        unk_reg <= 1'b1;
                    end
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                if (k_final) begin
                    k_reg     <= '0;
                    count_reg <= '0;
                    unk_reg   <= 1'b0;
                    ovf_reg   <= 1'b0;
                end else begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    // ---------------- fractionation positions ----------------
    logic [POS_W-1:0]  k_pos, n_pos, pos_a, pos_b;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic              sel_a, sel_b;

    assign k_pos = POS_W'(k_reg);
    assign n_pos = POS_W'(count_reg);

    always_comb begin
        if (dir_reg) begin
            // decrypt: list is r0 c0 r1 c1 ..., result k pairs k with k+n
            pos_a  = k_pos;
            pos_b  = k_pos + n_pos;
            addr_a = ADDR_W'(pos_a >> 1);
            addr_b = ADDR_W'(pos_b >> 1);
            sel_a  = pos_a[0];
            sel_b  = pos_b[0];
        end else begin
            // encrypt: list is all rows then all columns, read in pairs
            pos_a = k_pos << 1;
            pos_b = (k_pos << 1) | POS_W'(1);
            if (pos_a < n_pos) begin
                addr_a = ADDR_W'(pos_a);
                sel_a  = 1'b0;
            end else begin
                addr_a = ADDR_W'(pos_a - n_pos);
                sel_a  = 1'b1;
            end
            if (pos_b < n_pos) begin
                addr_b = ADDR_W'(pos_b);
                sel_b  = 1'b0;
            end else begin
                addr_b = ADDR_W'(pos_b - n_pos);
                sel_b  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store && !msg_full) begin
            msg_mem[count_reg[ADDR_W-1:0]] <= rev_vld_rd_reg ? rev_rd_reg : '0;
        end
        if (cmd.ord) begin
            ca_reg    <= msg_mem[addr_a];
            cb_reg    <= msg_mem[addr_b];
            a_col_reg <= sel_a;
            b_col_reg <= sel_b;
        end
    end

    // ---------------- output register ----------------
    logic [SYM_W-1:0] out_sym_reg;
    logic             out_last_reg, out_unk_reg, out_ovf_reg, out_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sym_reg  <= sq_rd_reg;
            out_last_reg <= k_final;
            out_unk_reg  <= unk_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = out_sym_reg;
    assign m_tlast           = out_last_reg;
    assign m_tuser[USER_UNK] = out_unk_reg;
    assign m_tuser[USER_OVF] = out_ovf_reg;

    // ---------------- status ----------------
    assign stat.item_msg  = item_msg_reg;
    assign stat.item_last = item_last_reg;
    assign stat.item_rng  = item_rng_reg;
    assign stat.need_old  = cell_loaded_reg[cell_addr(item_coord_reg)]
                         && (sq_rd_reg != sym_reg);
    assign stat.old_hit   = rev_vld_rd_reg && (rev_rd_reg == item_coord_reg);
    assign stat.scan_end  = scan_at_end;
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.k_final   = k_final;

endmodule

>>> rtl/core/bifid_square_cipher.sv
// bifid_square_cipher: bifid cipher over a SQUARE_SIDE x SQUARE_SIDE square.
// Steps: a message word is looked up, then stored; a table write is looked up, then written;
//   if it displaces another symbol, that symbol's map entry is read and a rescan may relocate it.
// Output: each result takes a coordinate read, a square read and an output register load, one
//   sequencer state each; the load waits while the output register is full. One input word at a time.
// Reset: synchronous, active-low aresetn; clears map and cell valid bits, count, flags, direction.
module bifid_square_cipher
    import bsc_pkg::*;
#(
    parameter int SQUARE_SIDE      = DEF_SQUARE_SIDE,      // 2..8
    parameter int MESSAGE_CAPACITY = DEF_MESSAGE_CAPACITY  // 2..64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [5:0] cell_index, [13:6] symbol, [15:14] zero
    input  logic                 s_tuser,   // [0] action: 0 cell write, 1 message symbol
    input  logic                 s_tlast,   // final message symbol, starts output
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] out_symbol
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] unknown_seen, [1] overflowed
    output logic                 m_tlast,   // end_of_run
    // direction register: 0 encrypt, 1 decrypt
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    bsc_cmd_t  cmd;
    bsc_stat_t stat;

    // direction is a plain register, always writable
    assign cfg_ready = 1'b1;

    // Sequencer: one input word in flight. A table write stores the cell and
    // updates the reverse map; if it displaced a symbol that pointed here, the
    // square is rescanned in order to find that symbol's next-highest cell.
    bsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: square, reverse map, message coordinates, output register.
    // The output register lets a new input word in while a result waits.
    bsc_dp #(
        .SQUARE_SIDE      (SQUARE_SIDE),
        .MESSAGE_CAPACITY (MESSAGE_CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
